// ===== hw/rtl/procedural_backdrop_pixel_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the procedural backdrop pixel unit
// Shared concurrent assertion forms, clocked and held off during reset.
// ---------------------------------------------------------------------------
`ifndef PROCEDURAL_BACKDROP_PIXEL_UNIT_MACROS_SVH
`define PROCEDURAL_BACKDROP_PIXEL_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PBP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pbp_pkg.sv =====
// ---------------------------------------------------------------------------
// pbp_pkg
// Shared types and constants of the procedural backdrop pixel unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbp_pkg;

    // Default sizes
    localparam int unsigned MAX_DIM_DEFAULT    = 1024;
    localparam int unsigned SINE_DEPTH_DEFAULT = 1024;

    // Reset value of both reciprocal registers (65536 / 240)
    localparam logic [15:0] RECIP_RESET = 16'd273;

    // pi/2 in Q2.30, seed of the sine table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Output word
    localparam int unsigned PIXEL_WIDTH = 16;

    // Colour channels
    localparam int unsigned NUM_CH = 3;
    localparam int unsigned CH_R   = 0;
    localparam int unsigned CH_G   = 1;
    localparam int unsigned CH_B   = 2;

    // Per-channel gradient colour, signed Q2.16
    typedef logic signed [17:0] t_base [NUM_CH];

endpackage

// ===== hw/rtl/pbp_sine_rom.sv =====
// ---------------------------------------------------------------------------
// pbp_sine_rom
// Quarter-wave sine table, Q0.15 magnitudes, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbp_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = pbp_pkg::SINE_DEPTH_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] i_addr,
    output logic [14:0]                           o_mag
);
    import pbp_pkg::*;

    localparam int unsigned Depth = SINE_TABLE_DEPTH;

    typedef logic [14:0] t_rom [0:Depth];

    // Build round(32767*sin(pi/2*i/Depth)) by an eight-term Taylor series
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] val;
        for (int i = 0; i <= Depth; i++) begin
            x    = 64'(i) * HALF_PI_Q30 / 64'(Depth);
            sum  = x;
            term = x;
            for (int k = 1; k <= 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                case (k)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    6:       term = term / 64'd156;
                    default: term = term / 64'd210;
                endcase
                if ((k & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            val = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            if (val > 64'd32767) begin
                val = 64'd32767;
            end
            rom[i] = 15'(val);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_build_rom();

    // Registered table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag <= SINE_ROM[i_addr];
        end
    end

endmodule

// ===== hw/rtl/pbp_sine_lane.sv =====
// ---------------------------------------------------------------------------
// pbp_sine_lane
// Phase (Q0.16 turns) to signed Q1.15 sine, three register stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbp_sine_lane #(
    parameter int unsigned SINE_TABLE_DEPTH = pbp_pkg::SINE_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_phase,
    output logic signed [15:0] o_sine
);
    import pbp_pkg::*;

    localparam int unsigned Depth = SINE_TABLE_DEPTH;
    localparam int unsigned IW    = $clog2(4 * Depth);
    localparam int unsigned AW    = $clog2(Depth + 1);

    localparam logic [IW-1:0] QUAD1 = IW'(Depth);
    localparam logic [IW-1:0] QUAD2 = IW'(2 * Depth);
    localparam logic [IW-1:0] QUAD3 = IW'(3 * Depth);
    localparam logic [31:0]   SCALE = 32'(4 * Depth);
    localparam logic [AW-1:0] TOP   = AW'(Depth);

    logic [31:0]   n_idx_full;
    logic [IW-1:0] n_idx;
    logic [IW-1:0] n_off;
    logic [1:0]    n_quad;
    logic [AW-1:0] n_addr;

    logic [AW-1:0] r_addr;
    logic          r_neg_a;
    logic          r_neg_b;
    logic [14:0]   w_mag;

    // Split the table index into quadrant and offset, mirror odd quadrants
    always_comb begin
        n_idx_full = 32'(i_phase) * SCALE;
        n_idx      = n_idx_full[16 +: IW];
        if (n_idx >= QUAD3) begin
            n_quad = 2'd3;
            n_off  = n_idx - QUAD3;
        end else if (n_idx >= QUAD2) begin
            n_quad = 2'd2;
            n_off  = n_idx - QUAD2;
        end else if (n_idx >= QUAD1) begin
            n_quad = 2'd1;
            n_off  = n_idx - QUAD1;
        end else begin
            n_quad = 2'd0;
            n_off  = n_idx;
        end
        n_addr = n_quad[0] ? (TOP - AW'(n_off)) : AW'(n_off);
    end

    // Hold address and sign for the table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_addr  <= n_addr;
            r_neg_a <= n_quad[1];
            r_neg_b <= r_neg_a;
        end
    end

    pbp_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_addr(r_addr),
        .o_mag (w_mag)
    );

    // Negate the lower half-wave
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sine <= r_neg_b ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

endmodule

// ===== hw/rtl/pbp_gradient.sv =====
// ---------------------------------------------------------------------------
// pbp_gradient
// Three-segment vertical colour gradient, five register stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbp_gradient (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [15:0]   i_v,
    output pbp_pkg::t_base o_base
);
    import pbp_pkg::*;

    // Segment start, length and 2^32/length (floor)
    localparam logic [15:0] SEG_T0 [3] = '{16'd0, 16'd27525, 16'd43254};
    localparam logic [14:0] SEG_SPAN [3] = '{15'd27525, 15'd15729, 15'd22282};
    localparam logic [18:0] SEG_RECIP [3] = '{
        19'((64'd1 << 32) / 64'd27525),
        19'((64'd1 << 32) / 64'd15729),
        19'((64'd1 << 32) / 64'd22282)
    };
    // Colour at each knot, Q0.16, channel order R, G, B
    localparam logic [15:0] KNOT [4][NUM_CH] = '{
        '{16'd2818,  16'd3604,  16'd9503},
        '{16'd20316, 16'd9503,  16'd21627},
        '{16'd62915, 16'd27525, 16'd11796},
        '{16'd4588,  16'd4915,  16'd7537}
    };

    logic [1:0]         n_seg;
    logic [14:0]        n_w;
    logic signed [16:0] n_diff [NUM_CH];

    // Stage A: segment, offset, colour delta
    logic [1:0]  r_seg_a;
    logic [14:0] r_w_a;
    logic [15:0] r_mag_a [NUM_CH];
    logic        r_neg_a [NUM_CH];
    logic [15:0] r_c0_a  [NUM_CH];
    // Stage B: delta times offset
    logic [1:0]  r_seg_b;
    logic [30:0] r_m_b   [NUM_CH];
    logic        r_neg_b [NUM_CH];
    logic [15:0] r_c0_b  [NUM_CH];
    // Stage C: quotient estimate
    logic [1:0]  r_seg_c;
    logic [30:0] r_m_c   [NUM_CH];
    logic [15:0] r_qe_c  [NUM_CH];
    logic        r_neg_c [NUM_CH];
    logic [15:0] r_c0_c  [NUM_CH];
    // Stage D: remainder of the estimate
    logic [1:0]  r_seg_d;
    logic [15:0] r_rem_d [NUM_CH];
    logic [15:0] r_qe_d  [NUM_CH];
    logic        r_neg_d [NUM_CH];
    logic [15:0] r_c0_d  [NUM_CH];

    logic [49:0]        n_p   [NUM_CH];
    logic [30:0]        n_qs  [NUM_CH];
    logic [30:0]        n_rem [NUM_CH];
    logic [16:0]        n_q   [NUM_CH];
    logic signed [17:0] n_step [NUM_CH];

    // Pick the segment the row falls in
    always_comb begin
        if (i_v < SEG_T0[1]) begin
            n_seg = 2'd0;
        end else if (i_v < SEG_T0[2]) begin
            n_seg = 2'd1;
        end else begin
            n_seg = 2'd2;
        end
        n_w = 15'(i_v - SEG_T0[n_seg]);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_diff[ch] = $signed({1'b0, KNOT[2'(n_seg + 2'd1)][ch]})
                       - $signed({1'b0, KNOT[n_seg][ch]});
        end
    end

    // Reciprocal estimate, remainder and correction per channel
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_p[ch]    = 50'(r_m_b[ch]) * 50'(SEG_RECIP[r_seg_b]);
            n_qs[ch]   = 31'(r_qe_c[ch]) * 31'(SEG_SPAN[r_seg_c]);
            n_rem[ch]  = r_m_c[ch] - n_qs[ch];
            n_q[ch]    = (r_rem_d[ch] >= {1'b0, SEG_SPAN[r_seg_d]})
                       ? 17'(r_qe_d[ch]) + 17'd1 : 17'(r_qe_d[ch]);
            n_step[ch] = r_neg_d[ch] ? -$signed({1'b0, n_q[ch]}) : $signed({1'b0, n_q[ch]});
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg_a <= n_seg;
            r_w_a   <= n_w;
            r_seg_b <= r_seg_a;
            r_seg_c <= r_seg_b;
            r_seg_d <= r_seg_c;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_neg_a[ch] <= n_diff[ch][16];
                r_mag_a[ch] <= n_diff[ch][16] ? 16'(-n_diff[ch]) : 16'(n_diff[ch]);
                r_c0_a[ch]  <= KNOT[n_seg][ch];

                r_m_b[ch]   <= 31'(r_mag_a[ch]) * 31'(r_w_a);
                r_neg_b[ch] <= r_neg_a[ch];
                r_c0_b[ch]  <= r_c0_a[ch];

                r_m_c[ch]   <= r_m_b[ch];
                r_qe_c[ch]  <= n_p[ch][47:32];
                r_neg_c[ch] <= r_neg_b[ch];
                r_c0_c[ch]  <= r_c0_b[ch];

                r_rem_d[ch] <= n_rem[ch][15:0];
                r_qe_d[ch]  <= r_qe_c[ch];
                r_neg_d[ch] <= r_neg_c[ch];
                r_c0_d[ch]  <= r_c0_c[ch];

                o_base[ch]  <= $signed({2'b00, r_c0_d[ch]}) + n_step[ch];
            end
        end
    end

endmodule

// ===== hw/rtl/pbp_out_buffer.sv =====
// ---------------------------------------------------------------------------
// pbp_out_buffer
// Two-word output register with skid slot; registered pipeline advance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "procedural_backdrop_pixel_unit_macros.svh"

module pbp_out_buffer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic [pbp_pkg::PIXEL_WIDTH-1:0]  i_data,
    output logic                             o_advance,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [pbp_pkg::PIXEL_WIDTH-1:0]  o_tdata
);
    import pbp_pkg::*;

    logic                   r_main_vld;
    logic [PIXEL_WIDTH-1:0] r_main;
    logic                   r_skid_vld;
    logic [PIXEL_WIDTH-1:0] r_skid;
    logic                   w_push;
    logic                   w_pop;

    // Pipeline moves only while the skid slot is free
    assign o_advance = ~r_skid_vld;
    assign w_push    = i_vld & ~r_skid_vld;
    assign w_pop     = r_main_vld & i_tready;
    assign o_tvalid  = r_main_vld;
    assign o_tdata   = r_main;

    // Fill main first, park in skid when main is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) begin
                r_main     <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_main_vld || w_pop) begin
                r_main     <= i_data;
                r_main_vld <= 1'b1;
            end else begin
                r_skid     <= i_data;
                r_skid_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_vld <= 1'b0;
        end
    end

    `PBP_ASSERT_SAME(a_skid_needs_main, i_clk, i_rst_n, r_skid_vld, r_main_vld, "skid word without main word")
    `PBP_ASSERT_NEXT(a_stall_parks_word, i_clk, i_rst_n, r_main_vld && !i_tready && w_push, r_skid_vld, "stalled word not parked")
    `PBP_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_vld && i_tready, !r_skid_vld && r_main_vld, "skid word not moved to main")

endmodule

// ===== hw/rtl/procedural_backdrop_pixel_unit.sv =====
// ---------------------------------------------------------------------------
// procedural_backdrop_pixel_unit
// One RGB565 backdrop pixel per accepted (column, row) word.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries column (bits 9..0) and row (bits 19..10).
//   Master stream m_axis returns the RGB565 pixel, one word per input word,
//   in input order. Register 0 holds the width reciprocal, register 1 the
//   height reciprocal (both Q0.16, reset to 273); write them through the
//   cfg channel, which is ready whenever reset is released, only while no
//   pixel is in flight.
//   A word accepted from s_axis passes through the ten-stage pipeline and
//   then the output register before it shows on m_axis_tvalid.
//   Throughput: one word per clock while no stall holds the pipeline; the
//   three sine lookups each use their own table copy.
//   When the receiver stalls, the pipeline keeps moving until the output
//   register and its one-word skid slot are both full; s_axis_tready then
//   drops and every stage holds. Reset empties the pipeline and the output
//   buffer and restores both reciprocals; both ready outputs stay low in it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module procedural_backdrop_pixel_unit #(
    parameter int unsigned MAX_DIM          = pbp_pkg::MAX_DIM_DEFAULT,
    parameter int unsigned SINE_TABLE_DEPTH = pbp_pkg::SINE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // column [9:0], row [19:10], zero [23:20]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // pixel [15:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [pbp_pkg::PIXEL_WIDTH-1:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import pbp_pkg::*;

    localparam int unsigned NUM_STAGES = 10;

    // Register indexes
    localparam logic [7:0] CFG_WIDTH_RECIP  = 8'd0;
    localparam logic [7:0] CFG_HEIGHT_RECIP = 8'd1;

    // Largest coordinate used
    localparam logic [9:0] COORD_MAX = 10'((MAX_DIM - 1 > 1023) ? 1023 : MAX_DIM - 1);

    // Sine lanes: two ribbons and the fine band
    localparam int unsigned NUM_LANES = 3;
    localparam int unsigned LANE_RIB1 = 0;
    localparam int unsigned LANE_RIB2 = 1;
    localparam int unsigned LANE_BAND = 2;
    localparam logic signed [17:0] PH_KU [NUM_LANES] = '{18'sd14081, -18'sd8344, 18'sd76142};
    localparam logic signed [17:0] PH_KV [NUM_LANES] = '{-18'sd6467, 18'sd19818, 18'sd42764};
    localparam logic [15:0]        PH_K0 [NUM_LANES] = '{16'd1147, 16'd4902, 16'd0};

    // Mixing weights
    localparam logic signed [30:0] RIB1_W  = 31'sd5571;
    localparam logic signed [30:0] RIB2_W  = 31'sd3604;
    localparam logic [29:0]        BAND_W  = 30'd27525;
    localparam logic signed [31:0] RIB_G_W = 32'sd45875;
    localparam logic signed [31:0] RIB_B_W = 32'sd81920;
    localparam logic [31:0]        BAND_G_W = 32'd61604;
    localparam logic [31:0]        BAND_B_W = 32'd56361;

    // Quantizer levels
    localparam logic [5:0] LEVELS_5 = 6'd31;
    localparam logic [5:0] LEVELS_6 = 6'd63;

    // Phase in Q0.16 turns: upper half of (u*ku + v*kv) mod 2^32, plus offset
    function automatic logic [15:0] f_phase(
        input logic [15:0]        u,
        input logic [15:0]        v,
        input logic signed [17:0] ku,
        input logic signed [17:0] kv,
        input logic [15:0]        k0
    );
        logic signed [34:0] pu;
        logic signed [34:0] pv;
        logic signed [34:0] s;
        pu = $signed({1'b0, u}) * ku;
        pv = $signed({1'b0, v}) * kv;
        s  = pu + pv;
        return s[31:16] + k0;
    endfunction

    // Clamp to [0,1] and round to the given number of levels
    function automatic logic [5:0] f_quant(
        input logic signed [18:0] sum,
        input logic [5:0]         levels
    );
        logic [16:0] c;
        logic [22:0] p;
        logic [6:0]  q;
        if (sum < 0) begin
            c = 17'd0;
        end else if (sum > 19'sd65536) begin
            c = 17'd65536;
        end else begin
            c = 17'(sum);
        end
        p = 23'(c) * 23'(levels) + 23'd32768;
        q = p[22:16];
        return (q > {1'b0, levels}) ? levels : q[5:0];
    endfunction

    logic w_advance;
    logic w_accept;

    logic [15:0] r_width_recip;
    logic [15:0] r_height_recip;

    logic r_vld [1:NUM_STAGES];

    // Stage 1
    logic [9:0]  n_col;
    logic [9:0]  n_row;
    logic [26:0] n_prod_u;
    logic [26:0] n_prod_v;
    logic [15:0] r_u;
    logic [15:0] r_v;
    // Stage 2
    logic [15:0] r_phase [NUM_LANES];
    // Stage 5 (lane outputs) and stage 6 (gradient output)
    logic signed [15:0] w_sine [NUM_LANES];
    t_base              w_base;
    // Stage 6
    logic signed [30:0] n_rib_acc;
    logic [14:0]        n_band;
    logic signed [15:0] r_ribbon;
    logic [14:0]        r_c2;
    // Stage 7
    logic signed [31:0] n_rib_g;
    logic signed [31:0] n_rib_b;
    logic [14:0]        r_c4;
    logic signed [15:0] r_rib7 [NUM_CH];
    // Stage 8
    logic [14:0]        r_c8;
    logic signed [15:0] r_rib8 [NUM_CH];
    // Stage 9
    logic [14:0]        r_caust;
    logic signed [15:0] r_rib9 [NUM_CH];
    t_base              r_base7;
    t_base              r_base8;
    t_base              r_base9;
    // Stage 10
    logic [31:0]        n_band_g;
    logic [31:0]        n_band_b;
    logic [15:0]        n_band_part [NUM_CH];
    logic signed [18:0] r_sum [NUM_CH];
    // Output word
    logic [5:0]             n_q_r;
    logic [5:0]             n_q_g;
    logic [5:0]             n_q_b;
    logic [PIXEL_WIDTH-1:0] n_pixel;

    assign s_axis_tready = w_advance & i_rst_n;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign o_cfg_ready   = i_rst_n;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_recip  <= RECIP_RESET;
            r_height_recip <= RECIP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH_RECIP:  r_width_recip  <= i_cfg_data;
                CFG_HEIGHT_RECIP: r_height_recip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NUM_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_advance) begin
            r_vld[1] <= w_accept;
            for (int s = 2; s <= NUM_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Stage 1: pixel centre times reciprocal, saturated just below one
    always_comb begin
        n_col    = (s_axis_tdata[9:0] > COORD_MAX) ? COORD_MAX : s_axis_tdata[9:0];
        n_row    = (s_axis_tdata[19:10] > COORD_MAX) ? COORD_MAX : s_axis_tdata[19:10];
        n_prod_u = 27'({n_col, 1'b1}) * 27'(r_width_recip);
        n_prod_v = 27'({n_row, 1'b1}) * 27'(r_height_recip);
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_u <= (|n_prod_u[26:17]) ? 16'hFFFF : n_prod_u[16:1];
            r_v <= (|n_prod_v[26:17]) ? 16'hFFFF : n_prod_v[16:1];
        end
    end

    // Stage 2: sine phases
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_phase[k] <= f_phase(r_u, r_v, PH_KU[k], PH_KV[k], PH_K0[k]);
            end
        end
    end

    // Stages 3 to 5: sine lookups
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        pbp_sine_lane #(
            .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_advance),
            .i_phase(r_phase[k]),
            .o_sine (w_sine[k])
        );
    end

    // Stages 2 to 6: gradient
    pbp_gradient u_gradient (
        .i_clk (i_clk),
        .i_en  (w_advance),
        .i_v   (r_v),
        .o_base(w_base)
    );

    // Ribbon sum, band clipped at zero, channel ribbon weights, band sums
    always_comb begin
        n_rib_acc = 31'(w_sine[LANE_RIB1]) * RIB1_W + 31'(w_sine[LANE_RIB2]) * RIB2_W
                  + 31'sd16384;
        n_band    = w_sine[LANE_BAND][15] ? 15'd0 : w_sine[LANE_BAND][14:0];
        n_rib_g   = (32'(r_ribbon) * RIB_G_W + 32'sd32768) >>> 16;
        n_rib_b   = (32'(r_ribbon) * RIB_B_W + 32'sd32768) >>> 16;
        n_band_g  = (32'(r_caust) * BAND_G_W + 32'd32768) >> 16;
        n_band_b  = (32'(r_caust) * BAND_B_W + 32'd32768) >> 16;
        n_band_part[CH_R] = 16'(r_caust);
        n_band_part[CH_G] = n_band_g[15:0];
        n_band_part[CH_B] = n_band_b[15:0];
    end

    // Stages 6 to 10: band to the eighth power, weights, channel sums
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_ribbon <= 16'(n_rib_acc >>> 15);
            r_c2     <= 15'((30'(n_band) * 30'(n_band) + 30'd16384) >> 15);

            r_c4         <= 15'((30'(r_c2) * 30'(r_c2) + 30'd16384) >> 15);
            r_rib7[CH_R] <= r_ribbon;
            r_rib7[CH_G] <= 16'(n_rib_g);
            r_rib7[CH_B] <= 16'(n_rib_b);
            r_base7      <= w_base;

            r_c8    <= 15'((30'(r_c4) * 30'(r_c4) + 30'd16384) >> 15);
            r_rib8  <= r_rib7;
            r_base8 <= r_base7;

            r_caust <= 15'((30'(r_c8) * BAND_W + 30'd16384) >> 15);
            r_rib9  <= r_rib8;
            r_base9 <= r_base8;

            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_sum[ch] <= 19'(r_base9[ch]) + 19'(r_rib9[ch])
                           + $signed({3'b000, n_band_part[ch]});
            end
        end
    end

    // Quantize and pack RGB565
    always_comb begin
        n_q_r   = f_quant(r_sum[CH_R], LEVELS_5);
        n_q_g   = f_quant(r_sum[CH_G], LEVELS_6);
        n_q_b   = f_quant(r_sum[CH_B], LEVELS_5);
        n_pixel = {n_q_r[4:0], n_q_g, n_q_b[4:0]};
    end

    pbp_out_buffer u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_vld[NUM_STAGES]),
        .i_data   (n_pixel),
        .o_advance(w_advance),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule
